>>> sv/wheel_command_frame_parser_top_macros.svh
// assertion helpers for the wheel command frame parser
`ifndef WHEEL_COMMAND_FRAME_PARSER_TOP_MACROS_SVH
`define WHEEL_COMMAND_FRAME_PARSER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, held off during reset
`define WCFP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wcfp assertion failed");
// next-cycle implication, held off during reset
`define WCFP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wcfp assertion failed");
`else
`define WCFP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WCFP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/wcfp_pkg.sv
`default_nettype none

package wcfp_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'hAA;

    localparam int RAW_W = 16;
    localparam int RPM_W = 18;
    localparam int PROD_W = 36;
    localparam int FRAC_SHIFT = 16;

    // mrad/s to rpm*256 scale, times 2^16
    localparam logic signed [19:0] RPM_SCALE = 20'sd160211;
    localparam logic signed [PROD_W-1:0] RPM_ROUND = 36'sd32768;

    // frame position, one-hot
    typedef enum logic [5:0] {
        ST_HUNT = 6'b000001,
        ST_B1   = 6'b000010,
        ST_B2   = 6'b000100,
        ST_B3   = 6'b001000,
        ST_B4   = 6'b010000,
        ST_CHK  = 6'b100000
    } t_state;

    // checked frame handed to the converter
    typedef struct packed {
        logic                    valid;
        logic signed [RAW_W-1:0] left_mrad;
        logic signed [RAW_W-1:0] right_mrad;
    } t_frame;

endpackage

`default_nettype wire

>>> sv/wheel_command_frame_parser_top.sv
// channel   direction  word                         fields
// s_axis    in         8-bit tdata                  rx_byte
// m_axis    out        40-bit tdata                 left_rpm, right_rpm
//
// one byte can be accepted every clock while s_axis is not stalled; after the
// checksum byte is accepted, a good frame goes to the frame register, then
// through the multiply into the result register
// reset is synchronous, active low, and drops any frame in progress
// a result waiting on m_axis stalls s_axis only once a second checked frame
// is also waiting in the frame register; then every byte waits
`default_nettype none

module wheel_command_frame_parser_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata    // [17:0] left_rpm, [35:18] right_rpm, [39:36] zero
);

    wcfp_pkg::t_frame frame;
    logic frame_ready;
    logic signed [wcfp_pkg::RPM_W-1:0] left_rpm, right_rpm;

    // header hunt, running sum and checksum test
    wcfp_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_valid  (i_s_axis_tvalid),
        .i_byte        (i_s_axis_tdata),
        .o_byte_ready  (o_s_axis_tready),
        .o_frame       (frame),
        .i_frame_ready (frame_ready)
    );

    // mrad/s to rpm*256 fixed point, output register
    wcfp_rpm_conv u_conv (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame       (frame),
        .o_frame_ready (frame_ready),
        .o_rpm_valid   (o_m_axis_tvalid),
        .o_left_rpm    (left_rpm),
        .o_right_rpm   (right_rpm),
        .i_rpm_ready   (i_m_axis_tready)
    );

    // pack results, left wheel in the low bits
    assign o_m_axis_tdata = {4'b0000, right_rpm, left_rpm};

endmodule

`default_nettype wire

>>> sv/wcfp_parser.sv
`default_nettype none

`include "wheel_command_frame_parser_top_macros.svh"

module wcfp_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_byte_valid,
    input  wire logic [7:0]      i_byte,
    output logic                 o_byte_ready,
    output wcfp_pkg::t_frame     o_frame,
    input  wire logic            i_frame_ready
);

    wcfp_pkg::t_state r_state, n_state;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_pay0, r_pay1, r_pay2, r_pay3;
    logic [7:0] n_pay0, n_pay1, n_pay2, n_pay3;
    logic r_frm_valid, n_frm_valid;
    logic signed [wcfp_pkg::RAW_W-1:0] r_left_mrad, r_right_mrad;
    logic signed [wcfp_pkg::RAW_W-1:0] n_left_mrad, n_right_mrad;
    logic accept;

    assign o_byte_ready = !r_frm_valid || i_frame_ready;
    assign accept = i_byte_valid && o_byte_ready;

    always_comb begin
        n_state = r_state;
        n_sum = r_sum;
        n_pay0 = r_pay0;
        n_pay1 = r_pay1;
        n_pay2 = r_pay2;
        n_pay3 = r_pay3;
        n_frm_valid = r_frm_valid && !i_frame_ready;
        n_left_mrad = r_left_mrad;
        n_right_mrad = r_right_mrad;
        if (accept) begin
            case (r_state)
                wcfp_pkg::ST_B1: begin
                    n_pay0 = i_byte;
                    n_sum = r_sum + i_byte;
                    n_state = wcfp_pkg::ST_B2;
                end
                wcfp_pkg::ST_B2: begin
                    n_pay1 = i_byte;
                    n_sum = r_sum + i_byte;
                    n_state = wcfp_pkg::ST_B3;
                end
                wcfp_pkg::ST_B3: begin
                    n_pay2 = i_byte;
                    n_sum = r_sum + i_byte;
                    n_state = wcfp_pkg::ST_B4;
                end
                wcfp_pkg::ST_B4: begin
                    n_pay3 = i_byte;
                    n_sum = r_sum + i_byte;
                    n_state = wcfp_pkg::ST_CHK;
                end
                wcfp_pkg::ST_CHK: begin
                    // checksum byte is always consumed, even if it looks like a header
                    n_state = wcfp_pkg::ST_HUNT;
                    if (i_byte == r_sum) begin
                        n_frm_valid = 1'b1;
                        n_left_mrad = {r_pay1, r_pay0};
                        n_right_mrad = {r_pay3, r_pay2};
                    end
                end
                default: begin
                    n_state = wcfp_pkg::ST_HUNT;
                    if (i_byte == wcfp_pkg::HEADER_BYTE) begin
                        n_sum = i_byte;
                        n_state = wcfp_pkg::ST_B1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wcfp_pkg::ST_HUNT;
            r_sum <= 8'd0;
            r_frm_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sum <= n_sum;
            r_frm_valid <= n_frm_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pay0 <= n_pay0;
        r_pay1 <= n_pay1;
        r_pay2 <= n_pay2;
        r_pay3 <= n_pay3;
        r_left_mrad <= n_left_mrad;
        r_right_mrad <= n_right_mrad;
    end

    assign o_frame.valid = r_frm_valid;
    assign o_frame.left_mrad = r_left_mrad;
    assign o_frame.right_mrad = r_right_mrad;

    `WCFP_ASSERT_NXT(a_chk_match_gives_frame, i_clk, i_rst_n,
        accept && r_state == wcfp_pkg::ST_CHK && i_byte == r_sum, r_frm_valid)
    `WCFP_ASSERT_NXT(a_chk_returns_to_hunt, i_clk, i_rst_n,
        accept && r_state == wcfp_pkg::ST_CHK, r_state == wcfp_pkg::ST_HUNT)
    `WCFP_ASSERT_NXT(a_frame_held_on_stall, i_clk, i_rst_n, r_frm_valid && !i_frame_ready,
        r_frm_valid && $stable(r_left_mrad) && $stable(r_right_mrad))

endmodule

`default_nettype wire

>>> sv/wcfp_rpm_conv.sv
`default_nettype none

`include "wheel_command_frame_parser_top_macros.svh"

module wcfp_rpm_conv (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire wcfp_pkg::t_frame               i_frame,
    output logic                                o_frame_ready,
    output logic                                o_rpm_valid,
    output logic signed [wcfp_pkg::RPM_W-1:0]   o_left_rpm,
    output logic signed [wcfp_pkg::RPM_W-1:0]   o_right_rpm,
    input  wire logic                           i_rpm_ready
);

    logic signed [wcfp_pkg::PROD_W-1:0] prod_l, prod_r;
    logic r_out_valid;
    logic signed [wcfp_pkg::RPM_W-1:0] r_left_rpm, r_right_rpm;
    logic take;

    assign o_frame_ready = !r_out_valid || i_rpm_ready;
    assign take = i_frame.valid && o_frame_ready;

    // round to nearest, then arithmetic shift; the result always fits 18 bits
    always_comb begin
        prod_l = wcfp_pkg::PROD_W'(i_frame.left_mrad) * wcfp_pkg::PROD_W'(wcfp_pkg::RPM_SCALE)
                 + wcfp_pkg::RPM_ROUND;
        prod_r = wcfp_pkg::PROD_W'(i_frame.right_mrad) * wcfp_pkg::PROD_W'(wcfp_pkg::RPM_SCALE)
                 + wcfp_pkg::RPM_ROUND;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_frame_ready) begin
            r_out_valid <= i_frame.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_left_rpm <= prod_l[wcfp_pkg::FRAC_SHIFT +: wcfp_pkg::RPM_W];
            r_right_rpm <= prod_r[wcfp_pkg::FRAC_SHIFT +: wcfp_pkg::RPM_W];
        end
    end

    assign o_rpm_valid = r_out_valid;
    assign o_left_rpm = r_left_rpm;
    assign o_right_rpm = r_right_rpm;

    `WCFP_ASSERT_NXT(a_taken_frame_shows, i_clk, i_rst_n, take, r_out_valid)

endmodule

`default_nettype wire

>>> dv/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // frame layout: header, left lo/hi, right lo/hi, checksum
    localparam int POS_HUNT     = 0;
    localparam int POS_CHECKSUM = 5;

    // mrad/s to rpm*256, scaled by 2^16, with half an lsb for rounding
    localparam longint MRAD_TO_RPM_Q16 = 160211;
    localparam longint HALF_LSB_Q16    = 32768;

    // no handshake for this many cycles ends the run
    localparam int STUCK_LIMIT  = 4000;
    // long receiver hold-off, so that checked frames pile up
    localparam int HOLD_CYCLES  = 400;
    // the result trails the checksum byte through the frame and result registers
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        logic signed [wcfp_pkg::RPM_W-1:0] left_rpm;
        logic signed [wcfp_pkg::RPM_W-1:0] right_rpm;
    } t_rpm_pair;

    // tracks the frame parser and holds the wheel speeds still owed
    class wheel_speed_scoreboard;
        int unsigned  frame_pos;
        logic [7:0]   byte_sum;
        logic [7:0]   speed_bytes [4];
        t_rpm_pair    rpm_expected [$];
        int unsigned  errors;

        function new();
            frame_pos = POS_HUNT;
            byte_sum  = 8'h00;
            errors    = 0;
            foreach (speed_bytes[i]) speed_bytes[i] = 8'h00;
        endfunction

        // signed mrad/s to rpm*256, floor of the rounded product
        function logic signed [wcfp_pkg::RPM_W-1:0] mrad_to_rpm(logic [7:0] lo, logic [7:0] hi);
            logic signed [wcfp_pkg::RAW_W-1:0] raw;
            longint                            scaled;
            raw    = {hi, lo};
            scaled = (longint'(raw) * MRAD_TO_RPM_Q16 + HALF_LSB_Q16) >>> 16;
            return scaled[wcfp_pkg::RPM_W-1:0];
        endfunction

        // one accepted rx byte
        function void take_rx_byte(logic [7:0] rx_byte);
            t_rpm_pair pair;
            if (frame_pos == POS_HUNT) begin
                if (rx_byte == wcfp_pkg::HEADER_BYTE) begin
                    byte_sum  = rx_byte;
                    frame_pos = 1;
                end
            end else if (frame_pos < POS_CHECKSUM) begin
                // header value inside a frame is plain data
                speed_bytes[frame_pos-1] = rx_byte;
                byte_sum  = byte_sum + rx_byte;
                frame_pos = frame_pos + 1;
            end else begin
                // checksum byte is always consumed, good or bad
                frame_pos = POS_HUNT;
                if (rx_byte == byte_sum) begin
                    pair.left_rpm  = mrad_to_rpm(speed_bytes[0], speed_bytes[1]);
                    pair.right_rpm = mrad_to_rpm(speed_bytes[2], speed_bytes[3]);
                    rpm_expected.push_back(pair);
                end
            end
        endfunction

        // one accepted result word
        function void check_rpm_word(logic [39:0] word);
            t_rpm_pair                         want;
            logic signed [wcfp_pkg::RPM_W-1:0] got_left;
            logic signed [wcfp_pkg::RPM_W-1:0] got_right;
            got_left  = word[17:0];
            got_right = word[35:18];
            if (rpm_expected.size() == 0) begin
                $error("unexpected result word %h", word);
                errors++;
                return;
            end
            want = rpm_expected.pop_front();
            if (got_left !== want.left_rpm) begin
                $error("left_rpm: expected %0d, actual %0d", want.left_rpm, got_left);
                errors++;
            end
            if (got_right !== want.right_rpm) begin
                $error("right_rpm: expected %0d, actual %0d", want.right_rpm, got_right);
                errors++;
            end
            if (word[39:36] !== 4'h0) begin
                $error("pad: expected %0d, actual %0d", 4'h0, word[39:36]);
                errors++;
            end
        endfunction

        function int pending();
            return rpm_expected.size();
        endfunction
    endclass

    // clock, reset and stream signals
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'h00;    // [7:0] rx_byte
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;            // [17:0] left_rpm, [35:18] right_rpm, [39:36] zero

    // idle percentages for each side, changed per phase
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    // set by the stimulus to ask the receiver for a long hold-off
    bit          hold_req = 1'b0;
    int unsigned stuck_cycles = 0;

    wheel_speed_scoreboard sb = new();

    wheel_command_frame_parser_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // all drives are nonblocking at the edge, so values read here are the
    // ones that held just before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // results before bytes: a byte's own result still has to pass the frame and result registers
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                sb.check_rpm_word(o_m_axis_tdata);
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                sb.take_rx_byte(i_s_axis_tdata);
            end
        end
    end

    // watchdog: any handshake clears the count
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // offer one byte, with a random idle gap first, and wait until it is taken
    task automatic send_byte(input logic [7:0] rx_byte);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= rx_byte;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // full frame; a nonzero offset spoils the checksum
    task automatic send_frame(input logic [15:0] left_mrad, input logic [15:0] right_mrad,
                              input logic [7:0] chk_offset);
        logic [7:0] chk;
        chk = wcfp_pkg::HEADER_BYTE + left_mrad[7:0] + left_mrad[15:8] + right_mrad[7:0]
            + right_mrad[15:8] + chk_offset;
        send_byte(wcfp_pkg::HEADER_BYTE);
        send_byte(left_mrad[7:0]);
        send_byte(left_mrad[15:8]);
        send_byte(right_mrad[7:0]);
        send_byte(right_mrad[15:8]);
        send_byte(chk);
    endtask

    // mostly random speeds, now and then the full-scale ones
    function automatic logic [15:0] pick_speed();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // random traffic until about frame_bytes frame bytes have gone out
    task automatic send_random_traffic(input int unsigned frame_bytes);
        int unsigned sent;
        int unsigned pick;
        int unsigned count;
        sent = 0;
        while (sent < frame_bytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                send_frame(pick_speed(), pick_speed(), 8'h00);
                sent += 6;
            end else if (pick < 87) begin
                send_frame(pick_speed(), pick_speed(), 8'($urandom_range(1, 255)));
                sent += 6;
            end else if (pick < 93) begin
                // cut-short frame, the next frame gets swallowed into it
                count = $urandom_range(1, 4);
                send_byte(wcfp_pkg::HEADER_BYTE);
                repeat (count) send_byte(8'($urandom_range(0, 255)));
            end else begin
                // line noise, may hold a stray header
                count = $urandom_range(1, 3);
                repeat (count) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        // slow sender, very slow receiver
        send_idle_pct = 30;
        recv_idle_pct = 78;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: noise while hunting, full-scale speeds, minus one,
        // header value inside the payload, bad checksum equal to the header
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(16'h7FFF, 16'h8000, 8'h00);
        send_frame(16'hFFFF, 16'hAAAA, 8'h00);
        send_frame(16'h0201, 16'h0403, 8'hF6);
        send_frame(16'h0000, 16'h0001, 8'h00);
        send_random_traffic(320);

        // very slow sender, slow receiver
        send_idle_pct = 78;
        recv_idle_pct = 30;
        send_random_traffic(320);

        // no idling; receiver holds off while good frames keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        repeat (12) send_frame(pick_speed(), pick_speed(), 8'h00);
        send_random_traffic(260);
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);

        // wait for every owed result, the watchdog covers a hang
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
